// ===== rtl/pkts_pkg.sv =====
// ----------------------------------------------------------------------------
// pkts_pkg
// Shared types and constants of the per-key traffic statistics table.
// ----------------------------------------------------------------------------
package pkts_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        ACT_UPDATE = 2'd0,
        ACT_DUMP   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_UPDATED = 3'd0,
        KIND_CREATED = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_CLEARED = 3'd3,
        KIND_ENTRY   = 3'd4,
        KIND_EMPTY   = 3'd5
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic               load;       // capture input item
        logic               scan_clr;   // reset slot pointer
        logic               scan_inc;   // advance slot pointer
        logic               rd;         // read slot at pointer
        logic               claim;      // claim slot at used count
        logic               upd_found;  // update slot at pointer
        logic               clr_slot;   // zero counters at pointer
        logic               div_start;
        logic               emit;       // present result
        kind_t              kind;
        logic               zero_fields;
        logic               last;
    } pkts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic               match;      // key at pointer equals input key
        logic               ptr_at_end; // pointer equals used count
        logic               ptr_is_last;// pointer + 1 equals used count
        logic               full;
        logic               empty;
        logic               div_done;
        logic               out_busy;   // result register holds an item
    } pkts_sts_t;

endpackage

// ===== rtl/per_key_traffic_stats_table_top.sv =====
// ----------------------------------------------------------------------------
// per_key_traffic_stats_table_top
// Keyed traffic statistics table with update, clear and dump requests.
// ----------------------------------------------------------------------------
// Update: accept, read and compare each slot searched, write back the found slot
// (or claim one), read it, 48-bit serial divide, result; table full: result.
// Dump: one result per reported entry, each paced by the serial divider.
// Clear: zeroes the counters of each used slot; one request at a time.
// Reset empties the table; slot contents are written when a slot is claimed.
module per_key_traffic_stats_table_top
    import pkts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] flow_key,
    input  logic [31:0] tx_bytes_in,
    input  logic [31:0] rx_bytes_in,
    input  logic [15:0] latency_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [15:0] report_key,
    output logic [63:0] tx_total,
    output logic [63:0] rx_total,
    output logic [31:0] conn_total,
    output logic [15:0] mean_latency,
    output logic        last
);

    pkts_cmd_t cmd;
    pkts_sts_t sts;

    pkts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pkts_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .flow_key       (flow_key),
        .tx_bytes_in    (tx_bytes_in),
        .rx_bytes_in    (rx_bytes_in),
        .latency_sample (latency_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .report_key     (report_key),
        .tx_total       (tx_total),
        .rx_total       (rx_total),
        .conn_total     (conn_total),
        .mean_latency   (mean_latency),
        .last           (last)
    );

endmodule

// ===== rtl/pkts_div.sv =====
// ----------------------------------------------------------------------------
// pkts_div
// Restoring divider, 48 by 32 bits, one quotient bit a cycle, 16-bit saturate.
// ----------------------------------------------------------------------------
module pkts_div
    import pkts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [47:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[47]} - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[47]};
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (dvs_reg == '0) ? 16'd0 :
                      (|quo_reg[47:16]) ? 16'hFFFF : quo_reg[15:0];

endmodule

// ===== rtl/pkts_datapath.sv =====
// ----------------------------------------------------------------------------
// pkts_datapath
// Slot stores, slot pointer, counter update and result register.
// ----------------------------------------------------------------------------
module pkts_datapath
    import pkts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  pkts_cmd_t           cmd,
    output pkts_sts_t           sts,
    input  logic [15:0]         flow_key,
    input  logic [31:0]         tx_bytes_in,
    input  logic [31:0]         rx_bytes_in,
    input  logic [15:0]         latency_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          kind,
    output logic [15:0]         report_key,
    output logic [63:0]         tx_total,
    output logic [63:0]         rx_total,
    output logic [31:0]         conn_total,
    output logic [15:0]         mean_latency,
    output logic                last
);

    logic [15:0] key_mem [MAX_ENTRIES];
    logic [63:0] tx_mem  [MAX_ENTRIES];
    logic [63:0] rx_mem  [MAX_ENTRIES];
    logic [31:0] conn_mem[MAX_ENTRIES];
    logic [47:0] lat_mem [MAX_ENTRIES];
    logic [31:0] cnt_mem [MAX_ENTRIES];

    logic [15:0]        key_reg;
    logic [31:0]        tx_in_reg, rx_in_reg;
    logic [15:0]        lat_in_reg;
    logic [COUNT_W-1:0] used_reg, used_next;
    logic [COUNT_W-1:0] ptr_reg, ptr_next;
    logic [SLOT_W-1:0]  ptr_idx, wr_idx;

    logic [15:0] rd_key_reg;
    logic [63:0] rd_tx_reg, rd_rx_reg;
    logic [31:0] rd_conn_reg, rd_cnt_reg;
    logic [47:0] rd_lat_reg;

    logic        div_done;
    logic [15:0] div_q;

    logic        ov_reg;
    logic [2:0]  okind_reg;
    logic [15:0] okey_reg, oavg_reg;
    logic [63:0] otx_reg, orx_reg;
    logic [31:0] oconn_reg;
    logic        olast_reg;

    logic        has_lat;

    assign ptr_idx = ptr_reg[SLOT_W-1:0];
    assign wr_idx  = cmd.claim ? used_reg[SLOT_W-1:0] : ptr_idx;
    assign has_lat = (lat_in_reg != 16'd0);

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.scan_clr)
            ptr_next = '0;
        else if (cmd.scan_inc)
            ptr_next = ptr_reg + 1'b1;
        else if (cmd.claim)
            ptr_next = used_reg;
        used_next = used_reg + COUNT_W'(cmd.claim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            ptr_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            ptr_reg  <= ptr_next;
            if (cmd.emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= flow_key;
            tx_in_reg  <= tx_bytes_in;
            rx_in_reg  <= rx_bytes_in;
            lat_in_reg <= latency_sample;
        end
        if (cmd.claim)
        begin
            key_mem[wr_idx]  <= key_reg;
            tx_mem[wr_idx]   <= {32'd0, tx_in_reg};
            rx_mem[wr_idx]   <= {32'd0, rx_in_reg};
            conn_mem[wr_idx] <= 32'd1;
            lat_mem[wr_idx]  <= {32'd0, lat_in_reg};
            cnt_mem[wr_idx]  <= {31'd0, has_lat};
        end
        else if (cmd.upd_found)
        begin
            tx_mem[wr_idx]   <= rd_tx_reg + {32'd0, tx_in_reg};
            rx_mem[wr_idx]   <= rd_rx_reg + {32'd0, rx_in_reg};
            conn_mem[wr_idx] <= rd_conn_reg + 32'd1;
            lat_mem[wr_idx]  <= rd_lat_reg + {32'd0, lat_in_reg};
            cnt_mem[wr_idx]  <= rd_cnt_reg + {31'd0, has_lat};
        end
        else if (cmd.clr_slot)
        begin
            tx_mem[wr_idx]   <= '0;
            rx_mem[wr_idx]   <= '0;
            conn_mem[wr_idx] <= '0;
            lat_mem[wr_idx]  <= '0;
            cnt_mem[wr_idx]  <= '0;
        end
        if (cmd.rd)
        begin
            rd_key_reg  <= key_mem[ptr_idx];
            rd_tx_reg   <= tx_mem[ptr_idx];
            rd_rx_reg   <= rx_mem[ptr_idx];
            rd_conn_reg <= conn_mem[ptr_idx];
            rd_lat_reg  <= lat_mem[ptr_idx];
            rd_cnt_reg  <= cnt_mem[ptr_idx];
        end
        if (cmd.emit)
        begin
            okind_reg <= cmd.kind;
            olast_reg <= cmd.last;
            if (cmd.zero_fields)
            begin
                okey_reg  <= (cmd.kind == KIND_FULL) ? key_reg : 16'd0;
                otx_reg   <= '0;
                orx_reg   <= '0;
                oconn_reg <= '0;
                oavg_reg  <= '0;
            end
            else
            begin
                okey_reg  <= rd_key_reg;
                otx_reg   <= rd_tx_reg;
                orx_reg   <= rd_rx_reg;
                oconn_reg <= rd_conn_reg;
                oavg_reg  <= div_q;
            end
        end
    end

    pkts_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_lat_reg),
        .divisor  (rd_cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sts.match       = (rd_key_reg == key_reg);
    assign sts.ptr_at_end  = (ptr_reg == used_reg);
    assign sts.ptr_is_last = ((ptr_reg + 1'b1) == used_reg);
    assign sts.full        = (used_reg == COUNT_W'(MAX_ENTRIES));
    assign sts.empty       = (used_reg == '0);
    assign sts.div_done    = div_done;
    assign sts.out_busy    = ov_reg;

    assign out_valid    = ov_reg;
    assign kind         = okind_reg;
    assign report_key   = okey_reg;
    assign tx_total     = otx_reg;
    assign rx_total     = orx_reg;
    assign conn_total   = oconn_reg;
    assign mean_latency = oavg_reg;
    assign last         = olast_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= COUNT_W'(MAX_ENTRIES))
        else $error("slot count beyond table size");
    a_claim_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |-> !sts.full)
        else $error("claim on full table");
    a_used_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |=> used_reg == $past(used_reg) + 1'b1)
        else $error("slot count did not advance");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!ov_reg || out_ready))
        else $error("result overwritten");

endmodule

// ===== rtl/pkts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pkts_ctrl
// Sequencer for lookup, update, clear and dump of the statistics table.
// ----------------------------------------------------------------------------
module pkts_ctrl
    import pkts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [1:0] action,
    input  logic      out_ready,
    input  pkts_sts_t sts,
    output pkts_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_UPD_WR,
        S_UPD_RD,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT,
        S_SIMPLE,
        S_CLR
    } state_t;

    state_t    state_reg, state_next;
    logic      dump_reg, dump_next;
    logic      created_reg, created_next;
    kind_t     skind_reg, skind_next;
    logic      out_free;
    action_t   act;

    assign act      = action_t'(action);
    assign out_free = !sts.out_busy || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        dump_next    = dump_reg;
        created_next = created_reg;
        skind_next   = skind_reg;
        cmd          = '0;
        cmd.kind     = KIND_UPDATED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    unique case (act)
                        ACT_UPDATE:
                        begin
                            dump_next    = 1'b0;
                            created_next = 1'b0;
                            state_next   = S_SRCH_RD;
                        end
                        ACT_DUMP:
                        begin
                            dump_next = 1'b1;
                            if (sts.empty)
                            begin
                                skind_next = KIND_EMPTY;
                                state_next = S_SIMPLE;
                            end
                            else
                                state_next = S_UPD_RD;
                        end
                        ACT_CLEAR:  state_next = S_CLR;
                        ACT_NONE:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLR:
            begin
                if (sts.ptr_at_end)
                begin
                    skind_next = KIND_CLEARED;
                    state_next = S_SIMPLE;
                end
                else
                begin
                    cmd.clr_slot = 1'b1;
                    cmd.scan_inc = 1'b1;
                end
            end
            S_SRCH_RD:
            begin
                if (sts.ptr_at_end)
                begin
                    if (sts.full)
                    begin
                        skind_next = KIND_FULL;
                        state_next = S_SIMPLE;
                    end
                    else
                    begin
                        cmd.claim    = 1'b1;
                        created_next = 1'b1;
                        state_next   = S_UPD_RD;
                    end
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (sts.match)
                    state_next = S_UPD_WR;
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SRCH_RD;
                end
            end
            S_UPD_WR:
            begin
                cmd.upd_found = 1'b1;
                state_next    = S_UPD_RD;
            end
            S_UPD_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    if (dump_reg)
                    begin
                        cmd.kind = KIND_ENTRY;
                        cmd.last = sts.ptr_is_last;
                        if (sts.ptr_is_last)
                            state_next = S_IDLE;
                        else
                        begin
                            cmd.scan_inc = 1'b1;
                            state_next   = S_UPD_RD;
                        end
                    end
                    else
                    begin
                        cmd.kind   = created_reg ? KIND_CREATED : KIND_UPDATED;
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_SIMPLE:
            begin
                if (out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.kind        = skind_reg;
                    cmd.zero_fields = 1'b1;
                    cmd.last        = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            dump_reg    <= 1'b0;
            created_reg <= 1'b0;
            skind_reg   <= KIND_EMPTY;
        end
        else
        begin
            state_reg   <= state_next;
            dump_reg    <= dump_next;
            created_reg <= created_next;
            skind_reg   <= skind_next;
        end
    end

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.claim, cmd.upd_found, cmd.clr_slot}) <= 1)
        else $error("conflicting slot writes");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_div_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT && sts.div_done) |=> state_reg == S_EMIT)
        else $error("quotient not taken");

endmodule
